// ----- hw/rtl/lpc_pkg.sv -----
package lpc_pkg;

    // Request codes
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_MANUAL = 2'd1;
    localparam logic [1:0] REQ_PRESET = 2'd2;
    localparam logic [1:0] REQ_TARGET = 2'd3;

    // Preset codes
    localparam logic [1:0] PRESET_DOWN = 2'd0;
    localparam logic [1:0] PRESET_MID  = 2'd1;
    localparam logic [1:0] PRESET_UP   = 2'd2;
    localparam logic [1:0] PRESET_HOLD = 2'd3;

    // Command kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_VEL   = 2'd1;
    localparam logic [1:0] KIND_POWER = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DOWN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MID   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_UP    = 3'd5;

    // Field widths
    localparam int ANGLE_W  = 16;
    localparam int POS_W    = 10;
    localparam int TGT_W    = 16;
    localparam int PRE_W    = 9;
    localparam int MAXV_W   = 7;
    localparam int GAIN_W   = 16;
    localparam int VAL_W    = 11;
    localparam int ERR_W    = 17;
    localparam int DERR_W   = 18;
    localparam int PROD_P_W = GAIN_W + ERR_W;
    localparam int PROD_D_W = GAIN_W + DERR_W;
    localparam int SUM_W    = PROD_D_W + 1;
    localparam int PW_W     = SUM_W - 8;

    // Reset values of the configuration registers
    localparam logic [MAXV_W-1:0]        MAX_VELOCITY_RST = 7'd127;
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST    = 16'sd256;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST   = 16'sd0;

    // angle / 100 as floor(angle * 83887 / 2^23); exact over the full 16-bit range
    localparam int                 DIV100_MUL_W = 17;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 17'd83887;
    localparam int                 DIV100_SHIFT = 23;
    localparam int                 DIV100_PROD_W = ANGLE_W + DIV100_MUL_W;

    function automatic logic [POS_W-1:0] div100(input logic [ANGLE_W-1:0] a);
        logic [DIV100_PROD_W-1:0] p;
        p = DIV100_PROD_W'(a) * DIV100_PROD_W'(DIV100_MUL);
        return p[DIV100_SHIFT +: POS_W];
    endfunction

    // One item on its way from the state stage to the control-law stages
    typedef struct packed {
        logic                     power;
        logic [1:0]               kind;
        logic signed [VAL_W-1:0]  value;
        logic signed [ERR_W-1:0]  err;
        logic signed [DERR_W-1:0] derr;
    } pd_item_t;

endpackage

// ----- hw/rtl/lpc_req_if.sv -----
interface lpc_req_if import lpc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [ANGLE_W-1:0]       angle;
    logic signed [VAL_W-1:0]  manual_velocity;
    logic                     manual_enable;
    logic [1:0]               preset_select;
    logic signed [TGT_W-1:0]  new_target;

    modport source
    (
        output valid, req_type, angle, manual_velocity, manual_enable,
               preset_select, new_target,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, angle, manual_velocity, manual_enable,
               preset_select, new_target,
        output ready
    );
endinterface

// ----- hw/rtl/lpc_cmd_if.sv -----
interface lpc_cmd_if import lpc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [1:0]              command_kind;
    logic signed [VAL_W-1:0] command_value;

    modport source
    (
        output valid, command_kind, command_value,
        input  ready
    );

    modport sink
    (
        input  valid, command_kind, command_value,
        output ready
    );
endinterface

// ----- hw/rtl/lpc_cfg_if.sv -----
interface lpc_cfg_if import lpc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source
    (
        output valid, index, data,
        input  ready
    );

    modport sink
    (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- hw/rtl/lift_pd_position_controller_top.sv -----
// Lift PD position controller. Every request beat (tick, manual command,
// preset select, direct target) yields exactly one command beat, in order.
// The block takes one request per clock cycle and keeps that rate as long as
// the command side drains. A request passes three registers (input register,
// product register, output register) in that order before its command beat
// is presented. The controller state (mode, captured flag, pending preset,
// target, last error) is updated as an item leaves the input register, so
// back-to-back requests see each other's effects in order. angle/100 is a
// reciprocal multiply ahead of the input register; the PD law uses two 16-bit
// gain multipliers feeding a product register, then a sum, a round-toward-zero
// divide by 256 and a clamp to +/-max_velocity. Configuration writes are taken
// in any cycle and must only be issued while no request is in flight; unknown
// indexes are ignored.
module lift_pd_position_controller_top import lpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lpc_req_if.sink   request,
    lpc_cmd_if.source command,
    lpc_cfg_if.sink   cfg
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MAXV_W-1:0]        max_velocity_reg;
    logic signed [GAIN_W-1:0] prop_gain_reg;
    logic signed [GAIN_W-1:0] deriv_gain_reg;
    logic [PRE_W-1:0]         target_down_reg;
    logic [PRE_W-1:0]         target_mid_reg;
    logic [PRE_W-1:0]         target_up_reg;

    // Always ready: a write is registered at the edge that accepts it
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_velocity_reg <= MAX_VELOCITY_RST;
            prop_gain_reg    <= PROP_GAIN_RST;
            deriv_gain_reg   <= DERIV_GAIN_RST;
            target_down_reg  <= '0;
            target_mid_reg   <= '0;
            target_up_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MAX_VELOCITY: max_velocity_reg <= cfg.data[MAXV_W-1:0];
                CFG_PROP_GAIN:    prop_gain_reg    <= cfg.data;
                CFG_DERIV_GAIN:   deriv_gain_reg   <= cfg.data;
                CFG_TARGET_DOWN:  target_down_reg  <= cfg.data[PRE_W-1:0];
                CFG_TARGET_MID:   target_mid_reg   <= cfg.data[PRE_W-1:0];
                CFG_TARGET_UP:    target_up_reg    <= cfg.data[PRE_W-1:0];
                default:          ; // drop writes to unknown indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: hold the request beat and its position in degrees
    // ------------------------------------------------------------------
    logic                    s1_valid_reg;
    logic [1:0]              s1_req_reg;
    logic signed [VAL_W-1:0] s1_mvel_reg;
    logic                    s1_men_reg;
    logic [1:0]              s1_psel_reg;
    logic signed [TGT_W-1:0] s1_ntarg_reg;
    logic [POS_W-1:0]        s1_pos_reg;

    logic     pipe_ready;
    logic     s1_fire;
    pd_item_t item;

    // Take a new beat whenever the slot is empty or drains this cycle
    assign request.ready = !s1_valid_reg || pipe_ready;
    assign s1_fire       = s1_valid_reg && pipe_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            s1_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.ready && request.valid)
        begin
            s1_req_reg   <= request.req_type;
            s1_mvel_reg  <= request.manual_velocity;
            s1_men_reg   <= request.manual_enable;
            s1_psel_reg  <= request.preset_select;
            s1_ntarg_reg <= request.new_target;
            s1_pos_reg   <= div100(request.angle);
        end
    end

    // ------------------------------------------------------------------
    // Controller state: advance once per item as it leaves the input register
    // ------------------------------------------------------------------
    logic                     manual_mode_reg,     manual_mode_next;
    logic                     captured_reg,        captured_next;
    logic [1:0]               preset_state_reg,    preset_state_next;
    logic                     reload_pending_reg,  reload_pending_next;
    logic signed [TGT_W-1:0]  target_position_reg, target_position_next;
    logic signed [ERR_W-1:0]  last_error_reg,      last_error_next;

    logic signed [ERR_W-1:0]  pos_ext;
    logic signed [ERR_W-1:0]  err;
    logic signed [DERR_W-1:0] derr;
    logic signed [TGT_W-1:0]  tgt_eff;

    assign pos_ext = ERR_W'({1'b0, s1_pos_reg});

    always_comb
    begin
        manual_mode_next     = manual_mode_reg;
        captured_next        = captured_reg;
        preset_state_next    = preset_state_reg;
        reload_pending_next  = reload_pending_reg;
        target_position_next = target_position_reg;
        last_error_next      = last_error_reg;

        item.power = 1'b0;
        item.kind  = KIND_NONE;
        item.value = '0;

        // Apply a pending preset on a captured automatic tick
        tgt_eff = target_position_reg;
        if (reload_pending_reg)
        begin
            case (preset_state_reg)
                PRESET_DOWN: tgt_eff = TGT_W'(target_down_reg);
                PRESET_MID:  tgt_eff = TGT_W'(target_mid_reg);
                PRESET_UP:   tgt_eff = TGT_W'(target_up_reg);
                default:     tgt_eff = target_position_reg; // hold keeps target
            endcase
        end
        err  = ERR_W'(tgt_eff) - pos_ext;
        derr = DERR_W'(err) - DERR_W'(last_error_reg);
        item.err  = err;
        item.derr = derr;

        case (s1_req_reg)
            REQ_MANUAL:
            begin
                manual_mode_next = s1_men_reg;
                if (s1_men_reg)
                begin
                    item.kind  = KIND_VEL;
                    item.value = s1_mvel_reg;
                end
            end
            REQ_PRESET:
            begin
                preset_state_next   = s1_psel_reg;
                reload_pending_next = 1'b1;
            end
            REQ_TARGET:
            begin
                reload_pending_next  = 1'b0;
                target_position_next = s1_ntarg_reg;
            end
            default: // tick
            begin
                if (manual_mode_reg)
                begin
                    captured_next = 1'b0;
                end
                else if (!captured_reg)
                begin
                    // First automatic tick: capture the current position
                    target_position_next = TGT_W'(s1_pos_reg);
                    captured_next        = 1'b1;
                end
                else
                begin
                    if (reload_pending_reg && preset_state_reg == PRESET_HOLD)
                    begin
                        captured_next = 1'b0;
                    end
                    reload_pending_next  = 1'b0;
                    target_position_next = tgt_eff;
                    last_error_next      = err;
                    item.power           = 1'b1;
                    item.kind            = KIND_POWER;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_mode_reg     <= 1'b0;
            captured_reg        <= 1'b0;
            preset_state_reg    <= PRESET_DOWN;
            reload_pending_reg  <= 1'b0;
            target_position_reg <= '0;
            last_error_reg      <= '0;
        end
        else if (s1_fire)
        begin
            manual_mode_reg     <= manual_mode_next;
            captured_reg        <= captured_next;
            preset_state_reg    <= preset_state_next;
            reload_pending_reg  <= reload_pending_next;
            target_position_reg <= target_position_next;
            last_error_reg      <= last_error_next;
        end
    end

    // ------------------------------------------------------------------
    // PD law: products, sum, divide, clamp and the output register
    // ------------------------------------------------------------------
    lpc_pd_pipe u_pd_pipe
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (s1_valid_reg),
        .item_ready   (pipe_ready),
        .item         (item),
        .max_velocity (max_velocity_reg),
        .prop_gain    (prop_gain_reg),
        .deriv_gain   (deriv_gain_reg),
        .command      (command)
    );

endmodule

// ----- hw/rtl/lpc_pd_pipe.sv -----
module lpc_pd_pipe import lpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  pd_item_t                 item,
    input  logic [MAXV_W-1:0]        max_velocity,
    input  logic signed [GAIN_W-1:0] prop_gain,
    input  logic signed [GAIN_W-1:0] deriv_gain,
    lpc_cmd_if.source                command
);

    // Product stage
    logic                       p_valid_reg;
    logic                       p_power_reg;
    logic [1:0]                 p_kind_reg;
    logic signed [VAL_W-1:0]    p_value_reg;
    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_D_W-1:0] prod_d_reg;
    logic signed [PROD_P_W-1:0] prod_p_next;
    logic signed [PROD_D_W-1:0] prod_d_next;

    // Output stage
    logic                    out_valid_reg;
    logic [1:0]              out_kind_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic signed [VAL_W-1:0] out_value_next;

    logic out_take;
    logic p_take;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] biased;
    logic signed [PW_W-1:0]  pw;
    logic signed [PW_W-1:0]  lim;
    logic signed [PW_W-1:0]  pw_clamped;

    assign out_take   = !out_valid_reg || command.ready;
    assign p_take     = !p_valid_reg || out_take;
    assign item_ready = p_take;

    assign prod_p_next = PROD_P_W'(prop_gain) * PROD_P_W'(item.err);
    assign prod_d_next = PROD_D_W'(deriv_gain) * PROD_D_W'(item.derr);

    // Sum, divide by 256 toward zero, clamp
    always_comb
    begin
        sum    = SUM_W'(prod_p_reg) + SUM_W'(prod_d_reg);
        biased = sum + (sum[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
        pw     = biased[SUM_W-1:8];
        lim    = PW_W'({1'b0, max_velocity});
        if (pw > lim)
        begin
            pw_clamped = lim;
        end
        else if (pw < -lim)
        begin
            pw_clamped = -lim;
        end
        else
        begin
            pw_clamped = pw;
        end
        out_value_next = p_power_reg ? pw_clamped[VAL_W-1:0] : p_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_take)
            begin
                p_valid_reg <= item_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_take && item_valid)
        begin
            p_power_reg <= item.power;
            p_kind_reg  <= item.kind;
            p_value_reg <= item.value;
            prod_p_reg  <= prod_p_next;
            prod_d_reg  <= prod_d_next;
        end
        if (out_take && p_valid_reg)
        begin
            out_kind_reg  <= p_kind_reg;
            out_value_reg <= out_value_next;
        end
    end

    assign command.valid         = out_valid_reg;
    assign command.command_kind  = out_kind_reg;
    assign command.command_value = out_value_reg;

`ifndef SYNTH
    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_NONE) |-> (out_value_reg == '0))
        else $error("empty command carries a nonzero value");

    a_power_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_POWER)
            |-> (out_value_reg <= 11'sd127 && out_value_reg >= -11'sd127))
        else $error("power command outside the saturation range");

    a_product_held: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && !out_take) |=> p_valid_reg)
        else $error("product stage dropped an item under stall");
`endif

endmodule
